@@ src/lrt_pkg.sv @@
// ----------------------------------------------------------------------------
// lrt_pkg: shared types for the load recency tracker
// Request codes and the control bundle broadcast from the top level to the
// row of list cells.
// ----------------------------------------------------------------------------
package lrt_pkg;

	typedef enum logic [1:0] {
		REQ_MARK    = 2'd0,
		REQ_REMOVE  = 2'd1,
		REQ_COMPARE = 2'd2,
		REQ_NONE    = 2'd3
	} req_code_t;

	// Broadcast to every cell; all bits are already qualified by an accepted beat.
	typedef struct packed {
		logic mark;
		logic remove;
		logic evict;
	} lrt_ctl_t;

endpackage

@@ src/lrt_if.sv @@
// ----------------------------------------------------------------------------
// lrt_if: request and response channels of the load recency tracker
// Valid/ready channels; a beat moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface lrt_req_if #(
	parameter int ID_BITS = 8
);
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [ID_BITS-1:0] engine_id;
	logic [ID_BITS-1:0] other_id;

	modport source (output valid, req_type, engine_id, other_id, input ready);
	modport sink   (input valid, req_type, engine_id, other_id, output ready);
endinterface

interface lrt_rsp_if;
	logic valid;
	logic ready;
	logic less_recent;
	logic evicted;

	modport source (output valid, less_recent, evicted, input ready);
	modport sink   (input valid, less_recent, evicted, output ready);
endinterface

@@ src/load_recency_tracker.sv @@
// ----------------------------------------------------------------------------
// load_recency_tracker: LRU recency list of engine identifiers
// Response: the result beat is registered and appears in the cycle after the request beat.
// Throughput: one request per cycle while no response is held back; the list
// updates as a row of MAX_ENGINES cells, the match chain rippling through all.
// Reset: the list is empty and no result is pending.
// ----------------------------------------------------------------------------
module load_recency_tracker #(
	parameter int MAX_ENGINES = 16,
	parameter int ID_BITS     = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	lrt_req_if.sink   req,
	lrt_rsp_if.source rsp
);
	import lrt_pkg::*;

	logic              accept;
	lrt_ctl_t          ctl;
	logic [ID_BITS-1:0] cell_id    [MAX_ENGINES+1];
	logic [MAX_ENGINES:0] cell_valid;
	logic [MAX_ENGINES:0] hit_chain;
	logic [MAX_ENGINES:0] pv_chain;
	logic [MAX_ENGINES-1:0] b_after_a;
	logic [MAX_ENGINES-1:0] valid_vec;
	logic              is_mark;
	logic              is_remove;
	logic              is_compare;
	logic              less_d;

	logic              rsp_valid_q;
	logic              less_q;
	logic              evict_q;

	assign accept     = req.valid & req.ready;
	assign req.ready  = ~rsp_valid_q | rsp.ready;
	assign is_mark    = accept && (req.req_type == REQ_MARK);
	assign is_remove  = accept && (req.req_type == REQ_REMOVE);
	assign is_compare = accept && (req.req_type == REQ_COMPARE);

	// Drop the oldest entry only when the list is full and the identifier is new.
	assign ctl.mark   = is_mark;
	assign ctl.remove = is_remove;
	assign ctl.evict  = is_mark & cell_valid[MAX_ENGINES-1] & ~hit_chain[MAX_ENGINES];

	assign hit_chain[0]            = 1'b0;
	assign pv_chain[0]             = 1'b1;
	assign cell_id[MAX_ENGINES]    = '0;
	assign cell_valid[MAX_ENGINES] = 1'b0;

	for (genvar i = 0; i < MAX_ENGINES; i++) begin : g_cell
		lrt_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (ctl),
			.a_id           (req.engine_id),
			.b_id           (req.other_id),
			.right_id       (cell_id[i+1]),
			.right_valid    (cell_valid[i+1]),
			.hit_in         (hit_chain[i]),
			.left_post_valid(pv_chain[i]),
			.id_q           (cell_id[i]),
			.valid_q        (cell_valid[i]),
			.hit_out        (hit_chain[i+1]),
			.post_valid     (pv_chain[i+1]),
			.b_after_a      (b_after_a[i])
		);
	end

	assign valid_vec = cell_valid[MAX_ENGINES-1:0];

	// A missing first operand always ranks first; otherwise the second must be
	// found at or after it.
	assign less_d = ~hit_chain[MAX_ENGINES] | (|b_after_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req.ready) begin
			rsp_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			less_q  <= is_compare & less_d;
			evict_q <= ctl.evict;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.less_recent = less_q;
	assign rsp.evicted     = evict_q;

	// The valid cells always form one packed run starting at the oldest slot.
	a_packed : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + {{(MAX_ENGINES-1){1'b0}}, 1'b1})) == '0)
		else $error("recency list has a gap");

	a_mark_fills : assert property (@(posedge clk) disable iff (!arst_n)
		is_mark |=> cell_valid[0])
		else $error("list empty after a mark");

	a_evict_full : assert property (@(posedge clk) disable iff (!arst_n)
		ctl.evict |=> cell_valid[MAX_ENGINES-1] && rsp.evicted)
		else $error("eviction without a full list");

endmodule

@@ src/lrt_cell.sv @@
// ----------------------------------------------------------------------------
// lrt_cell: one entry of the recency list
// Holds one identifier and its valid bit. Takes its right neighbor's entry
// when an entry at or before it is removed or re-marked or the oldest one is
// dropped, and takes the new identifier as the first free slot after that shift.
// ----------------------------------------------------------------------------
module lrt_cell #(
	parameter int ID_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lrt_pkg::lrt_ctl_t  ctl,
	input  logic [ID_BITS-1:0] a_id,
	input  logic [ID_BITS-1:0] b_id,
	input  logic [ID_BITS-1:0] right_id,
	input  logic               right_valid,
	input  logic               hit_in,
	input  logic               left_post_valid,
	output logic [ID_BITS-1:0] id_q,
	output logic               valid_q,
	output logic               hit_out,
	output logic               post_valid,
	output logic               b_after_a
);
	import lrt_pkg::*;

	logic match_a;
	logic match_b;
	logic shift;
	logic load_new;

	assign match_a = valid_q && (id_q == a_id);
	assign match_b = valid_q && (id_q == b_id);
	// Hit chain is inclusive: true once the first operand is found here or to the left.
	assign hit_out = hit_in | match_a;
	assign b_after_a = match_b & hit_out;

	assign shift      = ((ctl.mark | ctl.remove) & hit_out) | ctl.evict;
	assign post_valid = shift ? right_valid : valid_q;
	assign load_new   = ctl.mark & ~post_valid & left_post_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= post_valid | load_new;
		end
	end

	always_ff @(posedge clk) begin
		if (load_new) begin
			id_q <= a_id;
		end else if (shift) begin
			id_q <= right_id;
		end
	end

endmodule

@@ sim/recency_checker.sv @@
// ----------------------------------------------------------------------------
// recency_checker: scoreboard for the load recency tracker
// Watches the request and response channels. Each accepted request is applied
// to a private copy of the recency list, and the response it should produce
// is queued. Each response beat is compared field by field with the oldest
// queued response.
// ----------------------------------------------------------------------------
module recency_checker #(
	parameter int MAX_ENGINES = 16,
	parameter int ID_BITS     = 8
) (
	input  logic clk,
	input  logic arst_n,
	lrt_req_if   req,
	lrt_rsp_if   rsp,
	output int   failures,
	output int   awaiting
);
	import lrt_pkg::*;

	// Positions given to identifiers that are not in the list during a compare.
	localparam int ABSENT_FIRST  = -2;
	localparam int ABSENT_SECOND = -1;

	typedef struct packed {
		logic less_recent;
		logic evicted;
	} recency_rsp_t;

	logic [ID_BITS-1:0] recency_order [MAX_ENGINES];
	int                 loaded_count = 0;
	int                 fail_count = 0;
	int                 outstanding = 0;
	recency_rsp_t       expected_rsp_q[$];

	assign failures = fail_count;
	assign awaiting = outstanding;

	function automatic int oldest_slot_of(logic [ID_BITS-1:0] id);
		for (int i = 0; i < loaded_count; i++) begin
			if (recency_order[i] == id) begin
				return i;
			end
		end
		return loaded_count;
	endfunction

	function automatic int newest_slot_of(logic [ID_BITS-1:0] id, int missing);
		int pos;
		pos = missing;
		for (int i = 0; i < loaded_count; i++) begin
			if (recency_order[i] == id) begin
				pos = i;
			end
		end
		return pos;
	endfunction

	function automatic void drop_slot(int slot);
		if (slot >= loaded_count) begin
			return;
		end
		for (int i = slot; i + 1 < loaded_count; i++) begin
			recency_order[i] = recency_order[i + 1];
		end
		loaded_count--;
	endfunction

	function automatic recency_rsp_t apply_request(req_code_t op, logic [ID_BITS-1:0] first_id,
			logic [ID_BITS-1:0] second_id);
		recency_rsp_t outcome;
		outcome = '0;
		case (op)
			REQ_MARK: begin
				drop_slot(oldest_slot_of(first_id));
				// Only an identifier that was absent can find the list still full here.
				if (loaded_count >= MAX_ENGINES) begin
					drop_slot(0);
					outcome.evicted = 1'b1;
				end
				recency_order[loaded_count] = first_id;
				loaded_count++;
			end
			REQ_REMOVE: begin
				drop_slot(oldest_slot_of(first_id));
			end
			REQ_COMPARE: begin
				outcome.less_recent = newest_slot_of(first_id, ABSENT_FIRST) <=
					newest_slot_of(second_id, ABSENT_SECOND);
			end
			default: begin
			end
		endcase
		return outcome;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		recency_rsp_t want;
		recency_rsp_t fresh;
		if (!arst_n) begin
			loaded_count = 0;
			expected_rsp_q.delete();
			outstanding = 0;
		end else begin
			// A response beat always belongs to an earlier request, so it is
			// matched before this cycle's request is queued.
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp_q.size() == 0) begin
					$error("response beat with no request outstanding");
					fail_count++;
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.less_recent !== want.less_recent) begin
						$error("less_recent: expected %0b, actual %0b", want.less_recent,
							rsp.less_recent);
						fail_count++;
					end
					if (rsp.evicted !== want.evicted) begin
						$error("evicted: expected %0b, actual %0b", want.evicted, rsp.evicted);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				fresh = apply_request(req_code_t'(req.req_type), req.engine_id,
					req.other_id);
				expected_rsp_q = {expected_rsp_q, fresh};
			end
			outstanding = expected_rsp_q.size();
		end
	end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the load recency tracker
// Drives marks, removes and compares with random gaps on both channels, first
// a directed sequence that fills the list and forces an eviction, then random
// traffic over a small pool of identifiers so that hits and evictions are
// common. The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
	import lrt_pkg::*;

	localparam int MAX_ENGINES     = 16;
	localparam int ID_BITS         = 8;
	localparam int HOLD_OFF_CYCLES = 60;
	// A pool a bit larger than the list keeps hits and evictions both frequent.
	localparam int POOL_TOP        = 23;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   src_idle_pct = 0;
	int   snk_idle_pct = 0;
	logic hold_toggle = 1'b0;
	int   failures;
	int   awaiting;

	lrt_req_if #(.ID_BITS(ID_BITS)) req_if ();
	lrt_rsp_if rsp_if ();

	load_recency_tracker #(
		.MAX_ENGINES(MAX_ENGINES),
		.ID_BITS(ID_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	recency_checker #(
		.MAX_ENGINES(MAX_ENGINES),
		.ID_BITS(ID_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.failures(failures),
		.awaiting(awaiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// Response side: random back-pressure, plus a long hold-off each time the
	// stimulus flips hold_toggle.
	initial begin
		int   hold_left;
		logic hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	function automatic logic [ID_BITS-1:0] pick_id();
		if ($urandom_range(99) < 15) begin
			return ID_BITS'($urandom_range(255));
		end
		return ID_BITS'($urandom_range(POOL_TOP));
	endfunction

	task automatic send_beat(req_code_t op, logic [ID_BITS-1:0] first_id,
			logic [ID_BITS-1:0] second_id);
		while ($urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.req_type  <= op;
		req_if.engine_id <= first_id;
		req_if.other_id  <= second_id;
		@(posedge clk);
		while (!req_if.ready) begin
			@(posedge clk);
		end
	endtask

	// Unused request codes are sent now and then but do not count toward the total.
	task automatic send_random(int count);
		int        sent;
		int        roll;
		req_code_t op;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(99);
			if (roll < 45) begin
				op = REQ_MARK;
			end else if (roll < 62) begin
				op = REQ_REMOVE;
			end else if (roll < 96) begin
				op = REQ_COMPARE;
			end else begin
				op = REQ_NONE;
			end
			send_beat(op, pick_id(), pick_id());
			if (op != REQ_NONE) begin
				sent++;
			end
		end
	endtask

	// Stop offering requests until every response has come back.
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		wait (awaiting == 0);
		@(posedge clk);
	endtask

	initial begin
		req_if.valid     = 1'b0;
		req_if.req_type  = REQ_NONE;
		req_if.engine_id = '0;
		req_if.other_id  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 16;
		snk_idle_pct = 56;

		// Both ends of the identifier range, then every compare outcome.
		send_beat(REQ_COMPARE, 8'd42, 8'd42);
		send_beat(REQ_MARK, 8'd0, 8'd0);
		send_beat(REQ_MARK, 8'd255, 8'd255);
		send_beat(REQ_COMPARE, 8'd0, 8'd255);
		send_beat(REQ_COMPARE, 8'd255, 8'd0);
		send_beat(REQ_COMPARE, 8'd0, 8'd0);
		send_beat(REQ_COMPARE, 8'd99, 8'd0);
		send_beat(REQ_COMPARE, 8'd255, 8'd99);
		send_beat(REQ_MARK, 8'd0, 8'd170);
		send_beat(REQ_REMOVE, 8'd77, 8'd85);
		send_beat(REQ_REMOVE, 8'd255, 8'd0);
		send_beat(REQ_NONE, 8'd170, 8'd85);
		// Fill the list, overflow it, then refresh an entry while it is full.
		for (int i = 1; i < MAX_ENGINES; i++) begin
			send_beat(REQ_MARK, ID_BITS'(i), 8'd0);
		end
		send_beat(REQ_MARK, 8'd200, 8'd0);
		send_beat(REQ_MARK, 8'd5, 8'd0);
		send_beat(REQ_COMPARE, 8'd5, 8'd200);

		send_random(150);
		hold_toggle <= ~hold_toggle;
		send_random(60);
		send_random(150);

		src_idle_pct = 56;
		snk_idle_pct = 16;
		send_random(170);
		drain();
		send_random(170);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		send_random(300);

		drain();
		repeat (3) @(posedge clk);
		if (failures == 0 && awaiting == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/lrt_pkg.sv
src/lrt_if.sv
src/lrt_cell.sv
src/load_recency_tracker.sv
sim/recency_checker.sv
sim/tb_top.sv
